// ----- design/tkfv_pkg.sv -----
`default_nettype none

package tkfv_pkg;

    // Field widths fixed by the word formats
    localparam int VALUE_W   = 32;
    localparam int TOPK_W    = 7;
    localparam int CNT_OUT_W = 16;

    // Defaults for the top-level parameters
    localparam int DEF_TABLE_DEPTH = 64;
    localparam int DEF_COUNT_BITS  = 16;

    // Input word: one element of the data set
    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic                      last;
    } t_in_word;

    // Output word: one result of the ranking
    typedef struct packed {
        logic signed [VALUE_W-1:0] value_res;
        logic [CNT_OUT_W-1:0]      count;
        logic                      overflow;
        logic                      last_res;
    } t_out_word;

    // Control broadcast from the sequencer to every cell
    typedef struct packed {
        logic               count_en;
        logic [VALUE_W-1:0] value;
        logic               clear;
        logic               mark_en;
    } t_cell_ctl;

endpackage

`default_nettype wire

// ----- design/tkfv_cell.sv -----
`default_nettype none

module tkfv_cell
    import tkfv_pkg::*;
#(
    parameter int COUNT_BITS = DEF_COUNT_BITS,
    parameter int IDX_W      = 6,
    parameter int CELL_IDX   = 0
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire t_cell_ctl             i_ctl,
    input  wire logic [IDX_W-1:0]      i_mark_idx,
    input  wire logic                  i_any_match,
    input  wire logic                  i_prev_occ,
    output logic                       o_occ,
    output logic                       o_match,
    // search token from the left neighbor
    input  wire logic                  i_tok_vld,
    input  wire logic                  i_tok_found,
    input  wire logic [VALUE_W-1:0]    i_tok_value,
    input  wire logic [COUNT_BITS-1:0] i_tok_cnt,
    input  wire logic [IDX_W-1:0]      i_tok_idx,
    // search token to the right neighbor
    output logic                       o_tok_vld,
    output logic                       o_tok_found,
    output logic [VALUE_W-1:0]         o_tok_value,
    output logic [COUNT_BITS-1:0]      o_tok_cnt,
    output logic [IDX_W-1:0]           o_tok_idx
);

    logic                  r_occ;
    logic                  r_emitted;
    logic [VALUE_W-1:0]    r_value;
    logic [COUNT_BITS-1:0] r_count;
    logic                  r_tok_vld;
    logic                  r_tok_found;
    logic [VALUE_W-1:0]    r_tok_value;
    logic [COUNT_BITS-1:0] r_tok_cnt;
    logic [IDX_W-1:0]      r_tok_idx;

    logic hit;
    logic alloc;
    logic eligible;
    logic take;
    logic mark_me;

    // Match against the broadcast word; claim the slot if this is the first free one
    assign hit      = r_occ && (r_value == i_ctl.value);
    assign alloc    = i_ctl.count_en && !i_any_match && i_prev_occ && !r_occ;
    assign mark_me  = i_ctl.mark_en && (i_mark_idx == IDX_W'(CELL_IDX));

    // Strict compare keeps the earlier slot on a tie
    assign eligible = r_occ && !r_emitted;
    assign take     = eligible && (!i_tok_found || (r_count > i_tok_cnt));

    // Occupancy and emitted marks
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ     <= 1'b0;
            r_emitted <= 1'b0;
            r_tok_vld <= 1'b0;
        end else begin
            r_tok_vld <= i_tok_vld;
            if (i_ctl.clear) begin
                r_occ     <= 1'b0;
                r_emitted <= 1'b0;
            end else if (alloc) begin
                r_occ     <= 1'b1;
                r_emitted <= 1'b0;
            end else if (mark_me) begin
                r_emitted <= 1'b1;
            end
        end
    end

    // Entry payload: load on allocate, bump on hit until saturated
    always_ff @(posedge i_clk) begin
        if (alloc) begin
            r_value <= i_ctl.value;
            r_count <= COUNT_BITS'(1);
        end else if (i_ctl.count_en && hit && (r_count != '1)) begin
            r_count <= r_count + COUNT_BITS'(1);
        end
    end

    // Advance the search token by one cell
    always_ff @(posedge i_clk) begin
        r_tok_found <= i_tok_found || eligible;
        if (take) begin
            r_tok_value <= r_value;
            r_tok_cnt   <= r_count;
            r_tok_idx   <= IDX_W'(CELL_IDX);
        end else begin
            r_tok_value <= i_tok_value;
            r_tok_cnt   <= i_tok_cnt;
            r_tok_idx   <= i_tok_idx;
        end
    end

    assign o_occ       = r_occ;
    assign o_match     = hit;
    assign o_tok_vld   = r_tok_vld;
    assign o_tok_found = r_tok_found;
    assign o_tok_value = r_tok_value;
    assign o_tok_cnt   = r_tok_cnt;
    assign o_tok_idx   = r_tok_idx;

endmodule

`default_nettype wire

// ----- design/top_k_frequent_values.sv -----
// Top-k frequent values.
// Input channel: i_in_valid / o_in_stall carry one data-set element per word;
// the word with last set closes the set. While counting, one word is taken
// every cycle: each cell of the chain compares its stored value with the
// incoming word and new values claim the first free cell.
// On the last word the block raises o_in_stall and ranks the table: a search
// token walks the chain one cell per cycle, keeping the highest count (the
// earlier cell on a tie). Each result therefore takes one full sweep of the
// chain, and a set ending with n results keeps the input stalled for n sweeps
// plus any wait for the output register.
// Results leave on o_out_valid / i_out_stall from an output register; a stall
// only delays the next result, nothing is lost. After the result carrying
// last_res is loaded, the table is cleared in the same cycle and input words
// are taken again while that result may still wait.
// Reset (synchronous, active low) empties the table, drops any pending
// result and sets top_k to 1. Users must write top_k (i_cfg_wr_en /
// i_cfg_wr_data) only while the block is idle, unchecked; zero acts as one.
`default_nettype none

module top_k_frequent_values
    import tkfv_pkg::*;
#(
    parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
    parameter int COUNT_BITS  = DEF_COUNT_BITS
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_wr_en,
    input  wire logic [TOPK_W-1:0] i_cfg_wr_data,
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire t_in_word          i_in_word,
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output t_out_word              o_out_word
);

    localparam int IDX_W  = $clog2(TABLE_DEPTH);
    localparam int DCNT_W = $clog2(TABLE_DEPTH + 1);

    localparam logic [1:0] S_COUNT = 2'd0;
    localparam logic [1:0] S_SWEEP = 2'd1;
    localparam logic [1:0] S_EMIT  = 2'd2;

    logic [1:0]            r_state;
    logic [1:0]            n_state;
    logic [TOPK_W-1:0]     r_top_k;
    logic [DCNT_W-1:0]     r_distinct;
    logic [DCNT_W-1:0]     r_emit_cnt;
    logic                  r_overflow;
    logic                  r_launch;
    logic                  n_launch;
    logic [VALUE_W-1:0]    r_win_value;
    logic [COUNT_BITS-1:0] r_win_cnt;
    logic                  r_out_valid;
    t_out_word             r_out_word;

    logic [TABLE_DEPTH-1:0] occ_vec;
    logic [TABLE_DEPTH-1:0] match_vec;
    logic [TABLE_DEPTH-1:0] prev_occ;
    logic                   any_match;
    logic                   full;
    logic                   in_acc;
    logic                   alloc;
    logic                   out_free;
    logic                   load;
    logic                   is_last;
    logic [TOPK_W-1:0]      k_eff;
    logic [TOPK_W-1:0]      n_lim;
    logic [CNT_OUT_W-1:0]   win_cnt_out;
    t_cell_ctl              ctl;

    // Token chain wires, one stage per cell
    logic                  tok_vld   [TABLE_DEPTH+1];
    logic                  tok_found [TABLE_DEPTH+1];
    logic [VALUE_W-1:0]    tok_value [TABLE_DEPTH+1];
    logic [COUNT_BITS-1:0] tok_cnt   [TABLE_DEPTH+1];
    logic [IDX_W-1:0]      tok_idx   [TABLE_DEPTH+1];

    // Handshake and table-level status
    assign o_in_stall = (r_state != S_COUNT);
    assign in_acc     = i_in_valid && !o_in_stall;
    assign any_match  = |match_vec;
    assign full       = occ_vec[TABLE_DEPTH-1];
    assign alloc      = in_acc && !any_match && !full;
    assign prev_occ   = {occ_vec[TABLE_DEPTH-2:0], 1'b1};
    assign out_free   = !r_out_valid || !i_out_stall;
    assign load       = (r_state == S_EMIT) && out_free;

    // Number of results for this set
    assign k_eff   = (r_top_k == '0) ? TOPK_W'(1) : r_top_k;
    assign n_lim   = (k_eff > TOPK_W'(r_distinct)) ? TOPK_W'(r_distinct) : k_eff;
    assign is_last = (TOPK_W'(r_emit_cnt) + TOPK_W'(1)) == n_lim;

    // Broadcast control to the cells
    always_comb begin
        ctl.count_en = in_acc;
        ctl.value    = i_in_word.value;
        ctl.clear    = load && is_last;
        ctl.mark_en  = tok_vld[TABLE_DEPTH];
    end

    // Inject an empty token at the head of the chain
    assign tok_vld[0]   = r_launch;
    assign tok_found[0] = 1'b0;
    assign tok_value[0] = '0;
    assign tok_cnt[0]   = '0;
    assign tok_idx[0]   = '0;

    for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
        tkfv_cell #(
            .COUNT_BITS (COUNT_BITS),
            .IDX_W      (IDX_W),
            .CELL_IDX   (g)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctl       (ctl),
            .i_mark_idx  (tok_idx[TABLE_DEPTH]),
            .i_any_match (any_match),
            .i_prev_occ  (prev_occ[g]),
            .o_occ       (occ_vec[g]),
            .o_match     (match_vec[g]),
            .i_tok_vld   (tok_vld[g]),
            .i_tok_found (tok_found[g]),
            .i_tok_value (tok_value[g]),
            .i_tok_cnt   (tok_cnt[g]),
            .i_tok_idx   (tok_idx[g]),
            .o_tok_vld   (tok_vld[g+1]),
            .o_tok_found (tok_found[g+1]),
            .o_tok_value (tok_value[g+1]),
            .o_tok_cnt   (tok_cnt[g+1]),
            .o_tok_idx   (tok_idx[g+1])
        );
    end

    // Saturate the winner's count to the output field
    if (COUNT_BITS > CNT_OUT_W) begin : g_sat
        assign win_cnt_out = (r_win_cnt[COUNT_BITS-1:CNT_OUT_W] != '0) ?
                             '1 : r_win_cnt[CNT_OUT_W-1:0];
    end else begin : g_nosat
        assign win_cnt_out = CNT_OUT_W'(r_win_cnt);
    end

    // Sequencer: count, sweep, emit
    always_comb begin
        n_state  = r_state;
        n_launch = 1'b0;
        case (r_state)
            S_COUNT: begin
                if (in_acc && i_in_word.last) begin
                    n_state  = S_SWEEP;
                    n_launch = 1'b1;
                end
            end
            S_SWEEP: begin
                if (tok_vld[TABLE_DEPTH]) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (load) begin
                    if (is_last) begin
                        n_state = S_COUNT;
                    end else begin
                        n_state  = S_SWEEP;
                        n_launch = 1'b1;
                    end
                end
            end
            default: begin
                n_state = S_COUNT;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_COUNT;
            r_launch    <= 1'b0;
            r_top_k     <= TOPK_W'(1);
            r_distinct  <= '0;
            r_emit_cnt  <= '0;
            r_overflow  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_launch <= n_launch;
            if (i_cfg_wr_en) begin
                r_top_k <= i_cfg_wr_data;
            end
            if (ctl.clear) begin
                r_distinct <= '0;
                r_overflow <= 1'b0;
                r_emit_cnt <= '0;
            end else begin
                if (alloc) begin
                    r_distinct <= r_distinct + DCNT_W'(1);
                end
                if (in_acc && !any_match && full) begin
                    r_overflow <= 1'b1;
                end
                if (load) begin
                    r_emit_cnt <= r_emit_cnt + DCNT_W'(1);
                end
            end
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Hold the winner, then load the output word
    always_ff @(posedge i_clk) begin
        if (tok_vld[TABLE_DEPTH]) begin
            r_win_value <= tok_value[TABLE_DEPTH];
            r_win_cnt   <= tok_cnt[TABLE_DEPTH];
        end
        if (load) begin
            r_out_word.value_res <= r_win_value;
            r_out_word.count     <= win_cnt_out;
            r_out_word.overflow  <= r_overflow;
            r_out_word.last_res  <= is_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    // Token reaches the tail only while a sweep is running
    a_tok_in_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        tok_vld[TABLE_DEPTH] |-> (r_state == S_SWEEP))
        else $error("search token at tail outside sweep");

    // Occupied cells form a prefix whose length is the distinct count
    a_occ_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(occ_vec) == 32'(r_distinct))
        else $error("occupancy does not match distinct count");

    // Every winner was found in an occupied cell
    a_win_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        tok_vld[TABLE_DEPTH] |-> tok_found[TABLE_DEPTH])
        else $error("sweep finished with no candidate");

    // The final result of a set empties the table
    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (load && is_last) |=> ((r_distinct == '0) && !r_overflow && (occ_vec == '0)))
        else $error("table not cleared after last result");

endmodule

`default_nettype wire

// ----- tb/top_k_frequent_values_tb.sv -----
`timescale 1ns / 1ps

module top_k_frequent_values_tb;
    import tkfv_pkg::*;

    localparam int TBL_DEPTH   = DEF_TABLE_DEPTH;
    localparam int CNT_BITS    = DEF_COUNT_BITS;
    localparam longint unsigned CNT_MAX = (64'd1 << CNT_BITS) - 1;
    localparam int CNT_SHOWN_MAX = (1 << CNT_OUT_W) - 1;
    localparam int DRAIN_CYCLES  = 2 * (TBL_DEPTH + 2) + 20;
    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int PHASE_WORDS   = 30;
    localparam int DIR_ROWS      = 20;

    typedef enum logic {ROW_WORD, ROW_CFG} t_row_kind;

    typedef struct packed {
        t_row_kind         kind;
        logic [TOPK_W-1:0] top_k;
        t_in_word          word;
        logic              typed;
        t_out_word         result;
    } t_dir_row;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_cfg_wr_en;
    logic [TOPK_W-1:0] i_cfg_wr_data;
    logic              i_in_valid;
    logic              o_in_stall;
    t_in_word          i_in_word;
    logic              o_out_valid;
    logic              i_out_stall = 1'b0;
    t_out_word         o_out_word;

    // Predictor state: one data set under count
    logic [VALUE_W-1:0] tbl_value [TBL_DEPTH];
    longint unsigned    tbl_count [TBL_DEPTH];
    bit                 tbl_done  [TBL_DEPTH];
    int                 n_distinct;
    bit                 tbl_overflow;
    logic [TOPK_W-1:0]  top_k_reg;

    t_out_word    pending_ranks [$];
    t_out_word    want_res;
    int           mismatches;
    longint       cycles;
    int           send_idle_pct;
    int           recv_stall_pct;
    int           hold_off_left;
    logic [31:0]  value_pool [8];
    t_dir_row     dir_rows [DIR_ROWS];

    top_k_frequent_values #(
        .TABLE_DEPTH(TBL_DEPTH),
        .COUNT_BITS (CNT_BITS)
    ) DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_wr_data(i_cfg_wr_data),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_in_word    (i_in_word),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_out_word   (o_out_word)
    );

    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    // Abort a hung run
    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("top_k_frequent_values verification failed");
            $finish;
        end
    end

    // Drive output stall: hold off while a long stretch is requested, else random
    always @(negedge i_clk) begin
        if (hold_off_left > 0) begin
            i_out_stall = 1'b1;
            hold_off_left--;
        end else begin
            i_out_stall = ($urandom_range(0, 99) < recv_stall_pct);
        end
    end

    // Compare each accepted result word with the oldest expected rank
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_ranks.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected word value %0d count %0d ovf %0b last %0b",
                         $time, o_out_word.value_res, o_out_word.count,
                         o_out_word.overflow, o_out_word.last_res);
            end else begin
                want_res = pending_ranks.pop_front();
                if (o_out_word.value_res !== want_res.value_res ||
                    o_out_word.count !== want_res.count ||
                    o_out_word.overflow !== want_res.overflow ||
                    o_out_word.last_res !== want_res.last_res) begin
                    mismatches++;
                    $display("%0t: expected value %0d count %0d ovf %0b last %0b",
                             $time, want_res.value_res, want_res.count,
                             want_res.overflow, want_res.last_res);
                    $display("%0t: got value %0d count %0d ovf %0b last %0b",
                             $time, o_out_word.value_res, o_out_word.count,
                             o_out_word.overflow, o_out_word.last_res);
                end
            end
        end
    end

    // Count one word; on the last word of a set rank the table and queue the results
    function automatic void tally_and_rank(input t_in_word w);
        int        slot;
        int        n_out;
        int        best;
        t_out_word r;
        slot = -1;
        for (int i = 0; i < n_distinct; i++) begin
            if (slot < 0 && tbl_value[i] == w.value)
                slot = i;
        end
        if (slot >= 0) begin
            if (tbl_count[slot] < CNT_MAX)
                tbl_count[slot]++;
        end else if (n_distinct < TBL_DEPTH) begin
            tbl_value[n_distinct] = w.value;
            tbl_count[n_distinct] = 1;
            tbl_done[n_distinct]  = 1'b0;
            n_distinct++;
        end else begin
            tbl_overflow = 1'b1;
        end
        if (!w.last)
            return;

        // Pick the highest count each round; the earlier slot wins a tie
        n_out = (top_k_reg == 0) ? 1 : int'(top_k_reg);
        if (n_out > n_distinct)
            n_out = n_distinct;
        for (int k = 0; k < n_out; k++) begin
            best = -1;
            for (int i = 0; i < n_distinct; i++) begin
                if (!tbl_done[i] && (best < 0 || tbl_count[i] > tbl_count[best]))
                    best = i;
            end
            tbl_done[best] = 1'b1;
            r.value_res = tbl_value[best];
            r.count     = (tbl_count[best] > CNT_SHOWN_MAX) ? CNT_SHOWN_MAX[CNT_OUT_W-1:0]
                                                            : tbl_count[best][CNT_OUT_W-1:0];
            r.overflow  = tbl_overflow;
            r.last_res  = (k == n_out - 1);
            pending_ranks.insert(pending_ranks.size(), r);
        end

        // Clear the table for the next set
        for (int i = 0; i < TBL_DEPTH; i++)
            tbl_done[i] = 1'b0;
        n_distinct   = 0;
        tbl_overflow = 1'b0;
    endfunction

    // Offer one word after a random gap and hold it until taken
    task automatic send_word(input t_in_word w, input bit typed, input t_out_word typed_res);
        int n_queued;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_in_word  = w;
        do @(posedge i_clk); while (o_in_stall);
        n_queued = pending_ranks.size();
        tally_and_rank(w);
        if (typed) begin
            while (pending_ranks.size() > n_queued)
                void'(pending_ranks.pop_back());
            pending_ranks.insert(pending_ranks.size(), typed_res);
        end
        @(negedge i_clk);
    endtask

    // Wait until every expected word is out and the block has settled, then write top_k
    task automatic write_top_k(input logic [TOPK_W-1:0] k);
        i_in_valid = 1'b0;
        while (pending_ranks.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        i_cfg_wr_en   = 1'b1;
        i_cfg_wr_data = k;
        @(negedge i_clk);
        i_cfg_wr_en = 1'b0;
        top_k_reg   = k;
    endtask

    function automatic t_dir_row mk_row(input t_row_kind kind, input logic [TOPK_W-1:0] k,
                                        input logic [31:0] v, input logic lst,
                                        input logic typed, input logic [31:0] rv,
                                        input logic [15:0] rc);
        t_dir_row row;
        row.kind            = kind;
        row.top_k           = k;
        row.word.value      = v;
        row.word.last       = lst;
        row.typed           = typed;
        row.result.value_res = rv;
        row.result.count    = rc;
        row.result.overflow = 1'b0;
        row.result.last_res = 1'b1;
        return row;
    endfunction

    // Random data sets: mostly short sets over a small pool, now and then a table overflow
    task automatic run_random_sets(input int n_words);
        int       sent;
        int       len;
        bit       long_set;
        t_in_word w;
        sent = 0;
        while (sent < n_words) begin
            long_set = ($urandom_range(0, 39) == 0);
            len = long_set ? $urandom_range(70, 76) : $urandom_range(1, 10);
            for (int j = 0; j < len; j++) begin
                if (long_set)
                    w.value = ($urandom_range(0, 7) == 0) ? value_pool[$urandom_range(0, 7)]
                                                          : $urandom;
                else
                    w.value = ($urandom_range(0, 3) == 0) ? $urandom
                                                          : value_pool[$urandom_range(0, 7)];
                w.last = (j == len - 1);
                send_word(w, 1'b0, '0);
            end
            sent += len;
        end
    endtask

    task automatic run_phase(input int s_pct, input int r_pct, input logic [TOPK_W-1:0] k,
                             input int hold);
        write_top_k(k);
        send_idle_pct  = s_pct;
        recv_stall_pct = r_pct;
        value_pool[0] = 32'h8000_0000;
        value_pool[1] = 32'h7FFF_FFFF;
        value_pool[2] = 32'h0000_0000;
        value_pool[3] = 32'hFFFF_FFFF;
        for (int i = 4; i < 8; i++)
            value_pool[i] = $urandom;
        hold_off_left = hold;
        run_random_sets(PHASE_WORDS);
    endtask

    initial begin
        t_in_word w;
        i_rst_n        = 1'b0;
        i_cfg_wr_en    = 1'b0;
        i_cfg_wr_data  = '0;
        i_in_valid     = 1'b0;
        i_in_word      = '0;
        mismatches     = 0;
        cycles         = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_off_left  = 0;
        n_distinct     = 0;
        tbl_overflow   = 1'b0;
        top_k_reg      = 1;
        for (int i = 0; i < TBL_DEPTH; i++)
            tbl_done[i] = 1'b0;

        // Directed words: extremes, a tie, top_k of zero, above distinct, a three-word set
        dir_rows[0]  = mk_row(ROW_WORD, 0, 32'h8000_0000, 1, 1, 32'h8000_0000, 1);
        dir_rows[1]  = mk_row(ROW_WORD, 0, 32'h7FFF_FFFF, 1, 1, 32'h7FFF_FFFF, 1);
        dir_rows[2]  = mk_row(ROW_WORD, 0, 32'h0000_0000, 0, 0, 0, 0);
        dir_rows[3]  = mk_row(ROW_WORD, 0, 32'hFFFF_FFFF, 0, 0, 0, 0);
        dir_rows[4]  = mk_row(ROW_WORD, 0, 32'hFFFF_FFFF, 0, 0, 0, 0);
        dir_rows[5]  = mk_row(ROW_WORD, 0, 32'h0000_0000, 0, 0, 0, 0);
        dir_rows[6]  = mk_row(ROW_WORD, 0, 32'h0000_0005, 1, 1, 32'h0000_0000, 2);
        dir_rows[7]  = mk_row(ROW_CFG,  0, 0, 0, 0, 0, 0);
        dir_rows[8]  = mk_row(ROW_WORD, 0, 32'd42, 1, 1, 32'd42, 1);
        dir_rows[9]  = mk_row(ROW_CFG,  7'd127, 0, 0, 0, 0, 0);
        dir_rows[10] = mk_row(ROW_WORD, 0, 32'd3, 0, 0, 0, 0);
        dir_rows[11] = mk_row(ROW_WORD, 0, 32'd3, 0, 0, 0, 0);
        dir_rows[12] = mk_row(ROW_WORD, 0, 32'd9, 0, 0, 0, 0);
        dir_rows[13] = mk_row(ROW_WORD, 0, 32'd7, 0, 0, 0, 0);
        dir_rows[14] = mk_row(ROW_WORD, 0, 32'd9, 0, 0, 0, 0);
        dir_rows[15] = mk_row(ROW_WORD, 0, 32'd3, 1, 0, 0, 0);
        dir_rows[16] = mk_row(ROW_CFG,  7'd64, 0, 0, 0, 0, 0);
        dir_rows[17] = mk_row(ROW_WORD, 0, 32'h5555_5555, 0, 0, 0, 0);
        dir_rows[18] = mk_row(ROW_WORD, 0, 32'hAAAA_AAAA, 0, 0, 0, 0);
        dir_rows[19] = mk_row(ROW_WORD, 0, 32'h5555_5555, 1, 0, 0, 0);

        repeat (7) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        for (int r = 0; r < DIR_ROWS; r++) begin
            if (dir_rows[r].kind == ROW_CFG)
                write_top_k(dir_rows[r].top_k);
            else
                send_word(dir_rows[r].word, dir_rows[r].typed, dir_rows[r].result);
        end

        // Overflow: more distinct values than slots, repeats of kept ones, last one dropped
        for (int i = 0; i < TBL_DEPTH + 6; i++) begin
            w.value = 32'd1000 + 7 * i;
            w.last  = 1'b0;
            send_word(w, 1'b0, '0);
        end
        w.value = 32'd1000;
        send_word(w, 1'b0, '0);
        w.value = 32'd1000 + 7 * (TBL_DEPTH - 1);
        send_word(w, 1'b0, '0);
        w.value = 32'd1000 + 7 * (TBL_DEPTH + 5);
        w.last  = 1'b1;
        send_word(w, 1'b0, '0);

        // Random phases; the first holds the receiver off so the block backs up
        run_phase(0, 0, TOPK_W'($urandom_range(2, 6)), 600);
        run_phase(88, 0, 7'd64, 0);
        run_phase(0, 88, 7'd1, 0);
        run_phase(16, 16, 7'd127, 0);
        run_phase(0, 0, 7'd0, 0);

        i_in_valid = 1'b0;
        while (pending_ranks.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (mismatches == 0)
            $display("top_k_frequent_values verification clean");
        else
            $display("top_k_frequent_values verification failed");
        $finish;
    end

endmodule
